// ===== rtl/core/ttsc_pkg.sv =====
// Shared types, constants and helper functions of the text time-sync clock.
package ttsc_pkg;

  localparam int unsigned WinLen = 14;

  localparam logic [7:0] FRAME_START = 8'hAA;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;

  // Capture offsets, counted from the first keyword character
  localparam logic [6:0] YR_ARM        = 7'd5;
  localparam logic [6:0] YR_HOUR_TENS  = 7'd45;
  localparam logic [6:0] YR_HOUR_UNITS = 7'd46;
  localparam logic [6:0] YR_MIN_TENS   = 7'd57;
  localparam logic [6:0] YR_MIN_UNITS  = 7'd58;
  localparam logic [6:0] YR_SEC_TENS   = 7'd69;
  localparam logic [6:0] YR_SEC_UNITS  = 7'd70;
  localparam logic [3:0] WD_ARM        = 4'd11;
  localparam logic [3:0] WD_FIRST      = 4'd13;
  localparam logic [3:0] WD_LAST       = 4'd15;
  localparam logic [3:0] MD_ARM        = 4'd13;
  localparam logic [3:0] MD_UNITS      = 4'd15;

  localparam logic [7:0] SEC_MIN_LAST = 8'd59;
  localparam logic [7:0] HOUR_LAST    = 8'd23;

  // Found flags
  localparam int unsigned FLAG_TIME = 0;
  localparam int unsigned FLAG_WDAY = 1;
  localparam int unsigned FLAG_MDAY = 2;
  localparam logic [2:0]  FLAGS_ALL = 3'b111;

  // Weekday codes
  localparam logic [3:0] WDAY_MON     = 4'd0;
  localparam logic [3:0] WDAY_TUE     = 4'd1;
  localparam logic [3:0] WDAY_WED     = 4'd2;
  localparam logic [3:0] WDAY_THU     = 4'd3;
  localparam logic [3:0] WDAY_FRI     = 4'd4;
  localparam logic [3:0] WDAY_SAT     = 4'd5;
  localparam logic [3:0] WDAY_SUN     = 4'd6;
  localparam logic [3:0] WDAY_UNKNOWN = 4'd7;
  localparam logic [3:0] WDAY_NEVER   = 4'd8;

  // Letter sums of the three-letter day names
  localparam logic [9:0] SUM_MON = 10'h12A;
  localparam logic [9:0] SUM_TUE = 10'h12E;
  localparam logic [9:0] SUM_WED = 10'h120;
  localparam logic [9:0] SUM_THU = 10'h131;
  localparam logic [9:0] SUM_FRI = 10'h121;
  localparam logic [9:0] SUM_SAT = 10'h128;
  localparam logic [9:0] SUM_SUN = 10'h136;

  localparam logic [7:0] TPS_RESET = 8'd15;

  localparam logic [7:0] KW_YEAR [6] = '{"Y", "e", "a", "r", ":", " "};
  localparam logic [7:0] KW_WDAY [12] = '{"D", "a", "y", " ", "o", "f", " ",
                                          "w", "e", "e", "k", ":"};
  localparam logic [7:0] KW_MDAY [14] = '{"D", "a", "y", " ", "o", "f", " ",
                                          "M", "o", "n", "t", "h", ":", " "};

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
    logic [3:0] weekday;
    logic [7:0] day_of_month;
    logic       frame_synced;
  } out_t;

  // Two ASCII digits to a value, modulo 256, no digit check
  function automatic logic [7:0] two_digits(logic [7:0] tens, logic [7:0] units);
    logic [7:0] t;
    logic [7:0] u;
    t = tens - ASCII_ZERO;
    u = units - ASCII_ZERO;
    return 8'((t << 3) + (t << 1) + u);
  endfunction

  function automatic logic [3:0] weekday_code(logic [9:0] sum);
    logic [3:0] code;
    case (sum)
      SUM_MON: code = WDAY_MON;
      SUM_TUE: code = WDAY_TUE;
      SUM_WED: code = WDAY_WED;
      SUM_THU: code = WDAY_THU;
      SUM_FRI: code = WDAY_FRI;
      SUM_SAT: code = WDAY_SAT;
      SUM_SUN: code = WDAY_SUN;
      default: code = WDAY_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/text_time_sync_clock_unit.sv =====
// Each result beat is registered: into the result register, or into the skid while the output stalls.
// One beat per cycle while the input is not stalled; all state updates in a single pass of logic.
// A two-deep output buffer (result register plus skid) keeps input stall registered.
// Reset: asynchronous, active low; clock 00:00:00, weekday never set, day 1,
// window and captures cleared, prescaler limit 15.
module text_time_sync_clock_unit
  import ttsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic [7:0] tps_q;
  logic [7:0] win_q [WinLen];
  logic [7:0] win_d [WinLen];
  logic [6:0] yoff_q, yoff_d;
  logic [3:0] wdoff_q, wdoff_d;
  logic [3:0] mdoff_q, mdoff_d;
  logic [9:0] sum_q, sum_d;
  logic [7:0] hold_q, hold_d;
  logic [2:0] flags_q, flags_d;
  logic [7:0] tick_q, tick_d;
  logic [7:0] hour_q, hour_d;
  logic [7:0] min_q, min_d;
  logic [7:0] sec_q, sec_d;
  logic [3:0] wday_q, wday_d;
  logic [7:0] mday_q, mday_d;

  logic       match_year, match_wday, match_mday;
  logic [7:0] b;
  logic       in_acc, out_free;
  out_t       res;

  logic       out_valid_q, skid_valid_q;
  out_t       out_q, skid_q;

  assign cfg_ready_o = 1'b1;
  assign b           = in_i.rx_byte;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    win_d   = win_q;
    yoff_d  = yoff_q;
    wdoff_d = wdoff_q;
    mdoff_d = mdoff_q;
    sum_d   = sum_q;
    hold_d  = hold_q;
    flags_d = flags_q;
    tick_d  = tick_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    wday_d  = wday_q;
    mday_d  = mday_q;
    match_year = 1'b0;
    match_wday = 1'b0;
    match_mday = 1'b0;

    if (in_i.cmd) begin
      // prescaler, then carry through seconds, minutes, hours
      if (tick_q != tps_q) begin
        tick_d = tick_q + 8'd1;
      end else begin
        tick_d = '0;
        if (sec_q != SEC_MIN_LAST) begin
          sec_d = sec_q + 8'd1;
        end else begin
          sec_d = '0;
          if (min_q != SEC_MIN_LAST) begin
            min_d = min_q + 8'd1;
          end else begin
            min_d  = '0;
            hour_d = (hour_q == HOUR_LAST) ? 8'd0 : hour_q + 8'd1;
          end
        end
      end
    end else if (b == FRAME_START) begin
      for (int i = 0; i < WinLen; i++) begin
        win_d[i] = '0;
      end
      yoff_d  = '0;
      wdoff_d = '0;
      mdoff_d = '0;
      sum_d   = '0;
      flags_d = '0;
    end else begin
      if (yoff_q != '0) begin
        yoff_d = yoff_q + 7'd1;
        if (yoff_d == YR_HOUR_TENS || yoff_d == YR_MIN_TENS || yoff_d == YR_SEC_TENS) begin
          hold_d = b;
        end else if (yoff_d == YR_HOUR_UNITS) begin
          hour_d = two_digits(hold_q, b);
        end else if (yoff_d == YR_MIN_UNITS) begin
          min_d = two_digits(hold_q, b);
        end else if (yoff_d == YR_SEC_UNITS) begin
          sec_d              = two_digits(hold_q, b);
          flags_d[FLAG_TIME] = 1'b1;
          yoff_d             = '0;
        end
      end

      if (wdoff_q != '0) begin
        wdoff_d = wdoff_q + 4'd1;
        if (wdoff_d >= WD_FIRST) begin
          sum_d = sum_q + {2'b00, b};
          if (wdoff_d == WD_LAST) begin
            wday_d             = weekday_code(sum_d);
            flags_d[FLAG_WDAY] = 1'b1;
            wdoff_d            = '0;
          end
        end
      end

      if (mdoff_q != '0) begin
        mdoff_d = mdoff_q + 4'd1;
        if (mdoff_d == MD_UNITS) begin
          mday_d             = two_digits(win_q[0], b);
          flags_d[FLAG_MDAY] = 1'b1;
          mdoff_d            = '0;
        end
      end

      // shift the window, newest byte at index 0
      win_d[0] = b;
      for (int i = 1; i < WinLen; i++) begin
        win_d[i] = win_q[i-1];
      end

      match_year = 1'b1;
      for (int j = 0; j < 6; j++) begin
        if (win_d[5-j] != KW_YEAR[j]) match_year = 1'b0;
      end
      match_wday = 1'b1;
      for (int j = 0; j < 12; j++) begin
        if (win_d[11-j] != KW_WDAY[j]) match_wday = 1'b0;
      end
      match_mday = 1'b1;
      for (int j = 0; j < 14; j++) begin
        if (win_d[13-j] != KW_MDAY[j]) match_mday = 1'b0;
      end

      // ignore new matches once the frame is synced
      if (flags_d != FLAGS_ALL) begin
        if (match_year) yoff_d = YR_ARM;
        if (match_wday) begin
          wdoff_d = WD_ARM;
          sum_d   = '0;
        end
        if (match_mday) mdoff_d = MD_ARM;
      end
    end

    res.hours        = hour_d;
    res.minutes      = min_d;
    res.seconds      = sec_d;
    res.weekday      = wday_d;
    res.day_of_month = mday_d;
    res.frame_synced = (flags_d == FLAGS_ALL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (cfg_valid_i) begin
      tps_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinLen; i++) begin
        win_q[i] <= '0;
      end
      yoff_q  <= '0;
      wdoff_q <= '0;
      mdoff_q <= '0;
      sum_q   <= '0;
      hold_q  <= '0;
      flags_q <= '0;
      tick_q  <= '0;
      hour_q  <= '0;
      min_q   <= '0;
      sec_q   <= '0;
      wday_q  <= WDAY_NEVER;
      mday_q  <= 8'd1;
    end else if (in_acc) begin
      win_q   <= win_d;
      yoff_q  <= yoff_d;
      wdoff_q <= wdoff_d;
      mdoff_q <= mdoff_d;
      sum_q   <= sum_d;
      hold_q  <= hold_d;
      flags_q <= flags_d;
      tick_q  <= tick_d;
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      wday_q  <= wday_d;
      mday_q  <= mday_d;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/core/ttsc_checker.sv =====
// Port-level checks of the text time-sync clock, bound to the top level.
module ttsc_checker
  import ttsc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input out_t       out_o
);

  // the skid stage only fills behind a held result
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // a beat into an empty output shows its result next cycle
  a_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> out_valid_o)
    else $error("result missing one cycle after accepted beat");

  // nothing invented: drained output with no new beat goes empty
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !in_stall_o && !in_valid_i) |=> !out_valid_o)
    else $error("result shown without an accepted beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_o)))
    else $error("stalled result changed");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.weekday <= WDAY_NEVER))
    else $error("weekday code out of range");

endmodule

bind text_time_sync_clock_unit ttsc_checker u_ttsc_checker (.*);
